/* rtl/core/erld_pkg.sv */
// Package for the escape run-length decoder: sizes, escape constants and the
// command record passed from the front end to the back end. No dependencies.
`default_nettype none

package erld_pkg;

	// Expanded bytes carried by one result (1 to 8).
	localparam int BYTES_PER_RESULT = 8;

	localparam logic [7:0] ESCAPE_BYTE   = 8'hFF;
	localparam logic [7:0] MIN_RUN_COUNT = 8'd3;

	// A run holds up to 256 bytes, so its length needs nine bits.
	localparam int CNT_W = 9;
	localparam logic [CNT_W-1:0] RESULT_BYTES = CNT_W'(BYTES_PER_RESULT);

	// Depth of the command queue between the front end and the back end.
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);

	// One expansion command: a byte value, how many copies, or a truncation mark.
	typedef struct packed {
		logic             trunc;
		logic [CNT_W-1:0] total;
		logic [7:0]       value;
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/core/erld_front.sv */
// Front end of the escape run-length decoder: parses literals and escape
// sequences and issues expansion commands. Depends on erld_pkg.
`default_nettype none

module erld_front import erld_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] in_byte,
	input  wire logic       block_end,
	output logic            push,
	output cmd_t            cmd
);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_COUNT = 2'd1,
		PH_BYTE  = 2'd2
	} phase_t;

	phase_t     phase_q;
	logic [7:0] held_q;

	// Command produced by the byte at the input, if any.
	always_comb begin
		push      = 1'b0;
		cmd.trunc = 1'b0;
		cmd.total = CNT_W'(1);
		cmd.value = in_byte;
		case (phase_q)
			PH_COUNT: begin
				if (in_byte >= MIN_RUN_COUNT) begin
					push      = block_end;
					cmd.trunc = 1'b1;
					cmd.total = '0;
					cmd.value = '0;
				end else begin
					push      = 1'b1;
					cmd.value = ESCAPE_BYTE;
					cmd.total = {1'b0, in_byte} + CNT_W'(1);
				end
			end
			PH_BYTE: begin
				push      = 1'b1;
				cmd.total = {1'b0, held_q} + CNT_W'(1);
			end
			default: begin
				if (in_byte == ESCAPE_BYTE) begin
					push      = block_end;
					cmd.trunc = 1'b1;
					cmd.total = '0;
					cmd.value = '0;
				end else begin
					push = 1'b1;
				end
			end
		endcase
		push = push & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_COUNT: begin
					if (in_byte >= MIN_RUN_COUNT) begin
						held_q  <= in_byte;
						phase_q <= PH_BYTE;
					end else begin
						phase_q <= PH_IDLE;
					end
				end
				PH_BYTE: begin
					phase_q <= PH_IDLE;
					held_q  <= '0;
				end
				default: begin
					phase_q <= (in_byte == ESCAPE_BYTE) ? PH_COUNT : PH_IDLE;
				end
			endcase
			// The end of a block always leaves the parser fresh.
			if (block_end) begin
				phase_q <= PH_IDLE;
				held_q  <= '0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/erld_cmd_fifo.sv */
// Small command queue between the decoder front end and back end.
// Depends on erld_pkg.
`default_nettype none

module erld_cmd_fifo import erld_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output logic      full,
	output logic      empty
);

	cmd_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (PTR_W+1)'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/erld_back.sv */
// Back end of the escape run-length decoder: expands one command at a time
// into packed results held in an output register. Depends on erld_pkg.
`default_nettype none

module erld_back import erld_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        head,
	input  wire logic        empty,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      out_bytes,
	output logic [3:0]       byte_count,
	output logic             run_end,
	output logic             truncated
);

	logic             work_valid_q;
	logic [7:0]       value_q;
	logic [CNT_W-1:0] remain_q;
	logic             trunc_q;

	logic             load;
	logic             last_piece;
	logic [3:0]       take;
	logic [63:0]      word;

	assign load       = work_valid_q && (!out_valid || out_ready);
	assign last_piece = trunc_q || (remain_q <= RESULT_BYTES);
	assign pop        = !empty && (!work_valid_q || (load && last_piece));

	always_comb begin
		take = (remain_q > RESULT_BYTES) ? 4'(BYTES_PER_RESULT) : remain_q[3:0];
		word = '0;
		for (int k = 0; k < BYTES_PER_RESULT; k++) begin
			if (4'(k) < take) begin
				word[8*k +: 8] = value_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (pop) begin
				work_valid_q <= 1'b1;
			end else if (load && last_piece) begin
				work_valid_q <= 1'b0;
			end
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			value_q  <= head.value;
			remain_q <= head.total;
			trunc_q  <= head.trunc;
		end else if (load) begin
			remain_q <= remain_q - RESULT_BYTES;
		end
		if (load) begin
			out_bytes  <= trunc_q ? 64'd0 : word;
			byte_count <= trunc_q ? 4'd0 : take;
			run_end    <= last_piece;
			truncated  <= trunc_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/escape_run_length_decoder_top.sv */
// Top level of the escape run-length decoder: joins the parsing front end,
// the command queue and the expanding back end. Depends on erld_pkg.
//
// Use of the block:
// The slave stream takes one compressed byte per request in s_tdata, with
// s_tlast marking the final byte of a compressed block. A byte other than
// 0xFF passes as one byte; 0xFF, a count n of 3 or more and a byte B give
// n+1 copies of B; 0xFF and a count below 3 give n+1 copies of 0xFF.
// The master stream delivers results of up to eight expanded bytes, first
// byte lowest, with the byte count beside them; m_tlast closes the results
// caused by one input byte and m_tuser flags an escape cut off by the end
// of a block (no bytes, count zero).
// Path: an accepted byte passes through the command queue, the work
// register and the output register. While the receiver is ready, literals
// flow at one byte per cycle and a run of n+1 bytes gives ceil((n+1)/8)
// results at one output request per cycle; the input keeps flowing into a
// four-entry command queue and stalls only when that queue is full.
// When the receiver stalls, the current result holds on the master side and
// the queue fills up behind it before s_tready drops.
// Reset empties the queue and the output register and returns the parser to
// expecting a literal or an escape.
`default_nettype none

module escape_run_length_decoder_top import erld_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,   // block_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // [63:0] out_bytes, [67:64] byte_count, rest zero
	output logic             m_tlast,   // run_end
	output logic [0:0]       m_tuser    // [0] truncated
);

	logic        accept;
	logic        push;
	cmd_t        push_cmd;
	cmd_t        head;
	logic        full;
	logic        empty;
	logic        pop;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic        run_end;
	logic        truncated;

	// A byte is taken whenever the queue has room, even if it issues no command.
	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	erld_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (s_tdata),
		.block_end (s_tlast),
		.push      (push),
		.cmd       (push_cmd)
	);

	erld_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	erld_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_bytes  (out_bytes),
		.byte_count (byte_count),
		.run_end    (run_end),
		.truncated  (truncated)
	);

	assign m_tdata = {4'd0, byte_count, out_bytes};
	assign m_tlast = run_end;
	assign m_tuser = truncated;

endmodule

`default_nettype wire
